### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/lcam_pkg.sv
// types, constants and helpers for the led current regulator
package lcam_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DC_W     = 20;
    localparam int TIME_W   = 32;
    localparam int CODE_W   = 4;
    localparam int RATIO_W  = 10;
    localparam int CFG_W    = 16;
    localparam int PROD_W   = RATIO_W + DC_W;

    localparam logic [TIME_W-1:0] MAIN_PERIOD_MS    = 32'd500;
    localparam logic [TIME_W-1:0] SUB_PERIOD_MS     = 32'd1000;
    localparam logic [CODE_W-1:0] IR_START_CURRENT  = 4'd8;
    localparam logic [CODE_W-1:0] RED_START_CURRENT = 4'd8;
    localparam logic [CODE_W-1:0] CODE_MAX          = 4'd15;
    localparam logic [DC_W-1:0]   DC_ONE            = 20'd16;

    localparam logic signed [2:0] STEP_BACKOFF = -3'sd3;
    localparam logic signed [2:0] STEP_DOWN2   = -3'sd2;
    localparam logic signed [2:0] STEP_DOWN1   = -3'sd1;
    localparam logic signed [2:0] STEP_NONE    = 3'sd0;
    localparam logic signed [2:0] STEP_UP1     = 3'sd1;
    localparam logic signed [2:0] STEP_UP2     = 3'sd2;

    localparam logic [CFG_W-1:0]   RST_NO_SIGNAL  = 16'd5000;
    localparam logic [CFG_W-1:0]   RST_SATURATION = 16'd60000;
    localparam logic [CFG_W-1:0]   RST_TARGET     = 16'd40000;
    localparam logic [CFG_W-1:0]   RST_BAND_BELOW = 16'd3000;
    localparam logic [CFG_W-1:0]   RST_BAND_ABOVE = 16'd3000;
    localparam logic [CFG_W-1:0]   RST_COARSE     = 16'd10000;
    localparam logic [RATIO_W-1:0] RST_RATIO_FLOOR = 10'd205;
    localparam logic [RATIO_W-1:0] RST_RATIO_CEIL  = 10'd307;

    typedef enum logic [1:0] {
        MODE_FEED    = 2'd0,
        MODE_RUN     = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CFG_NO_SIGNAL   = 3'd0,
        CFG_SATURATION  = 3'd1,
        CFG_TARGET      = 3'd2,
        CFG_BAND_BELOW  = 3'd3,
        CFG_BAND_ABOVE  = 3'd4,
        CFG_COARSE      = 3'd5,
        CFG_RATIO_FLOOR = 3'd6,
        CFG_RATIO_CEIL  = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MED_WAIT,
        ST_MAIN_ADJ,
        ST_MUL_FLOOR,
        ST_CMP_FLOOR,
        ST_MUL_CEIL,
        ST_CMP_CEIL,
        ST_EMIT_FIRST,
        ST_EMIT_LAST
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MED_IDLE,
        MED_CAND,
        MED_LOAD,
        MED_SCAN,
        MED_LAST
    } med_state_t;

    typedef struct packed {
        logic wr_en;
        logic clr;
        logic start;
    } med_ctrl_t;

    typedef struct packed {
        logic done;
        logic empty;
    } med_stat_t;

    // add a signed step to a current code, clamped to the code range
    function automatic logic [CODE_W-1:0] code_step(input logic [CODE_W-1:0] code,
                                                    input logic signed [2:0] step);
        logic signed [5:0] sum;
        sum = signed'({2'b00, code}) + signed'({{3{step[2]}}, step});
        if (sum[5]) begin
            return '0;
        end else if (sum > signed'({2'b00, CODE_MAX})) begin
            return CODE_MAX;
        end else begin
            return sum[CODE_W-1:0];
        end
    endfunction

endpackage

### rtl/core/lcam_median.sv
// sample window memory and iterative upper median search
module lcam_median #(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lcam_pkg::med_ctrl_t         ctrl,
    input  logic [lcam_pkg::SAMPLE_W-1:0] wr_data,
    output lcam_pkg::med_stat_t         stat,
    output logic [lcam_pkg::SAMPLE_W-1:0] median
);
    import lcam_pkg::*;

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

    logic [SAMPLE_W-1:0] mem [WINDOW_SIZE];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;

    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    med_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    lt_reg, lt_next;
    logic [CNT_W-1:0]    le_reg, le_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W-1:0] cand_reg, cand_next;
    logic [SAMPLE_W-1:0] med_reg, med_next;

    logic [CNT_W-1:0]    lt_sum, le_sum, rank;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_idx_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_addr = (state_reg == MED_SCAN) ? j_reg : i_reg;
    assign lt_sum  = lt_reg + CNT_W'(pend_reg && (rd_data_reg <  cand_reg));
    assign le_sum  = le_reg + CNT_W'(pend_reg && (rd_data_reg <= cand_reg));
    assign rank    = n_reg >> 1;

    always_comb begin
        wr_idx_next = wr_idx_reg;
        fill_next   = fill_reg;
        if (ctrl.clr) begin
            wr_idx_next = '0;
            fill_next   = '0;
        end else if (ctrl.wr_en) begin
            wr_idx_next = (wr_idx_reg == IDX_W'(WINDOW_SIZE - 1)) ? '0 : wr_idx_reg + 1'b1;
            if (fill_reg < CNT_W'(WINDOW_SIZE)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        lt_next    = lt_sum;
        le_next    = le_sum;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        cand_next  = cand_reg;
        med_next   = med_reg;
        unique case (state_reg)
            MED_IDLE: begin
                if (ctrl.start) begin
                    n_next     = fill_reg;
                    i_next     = '0;
                    state_next = MED_CAND;
                end
            end
            MED_CAND: begin
                state_next = MED_LOAD;
            end
            MED_LOAD: begin
                cand_next  = rd_data_reg;
                lt_next    = '0;
                le_next    = '0;
                j_next     = '0;
                state_next = MED_SCAN;
            end
            MED_SCAN: begin
                pend_next = 1'b1;
                if (CNT_W'(j_reg) + 1'b1 == n_reg) begin
                    state_next = MED_LAST;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            MED_LAST: begin
                if ((lt_sum <= rank) && (le_sum > rank)) begin
                    med_next   = cand_reg;
                    done_next  = 1'b1;
                    state_next = MED_IDLE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = MED_CAND;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= MED_IDLE;
            wr_idx_reg <= '0;
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        n_reg    <= n_next;
        lt_reg   <= lt_next;
        le_reg   <= le_next;
        cand_reg <= cand_next;
        med_reg  <= med_next;
    end

    assign stat.done  = done_reg;
    assign stat.empty = (fill_reg == '0);
    assign median     = med_reg;

endmodule

### rtl/core/led_current_agc_median_core.sv
// top level of the two-loop led drive current regulator
//
// input channel s_*: one word per item; mode feed stores an ir sample in the
// window, mode run performs a timed control step, mode restart reloads the
// start currents and empties the window. result channel m_*: one word per
// led register write, m_last marks the final write caused by an input word.
// feed gives no result and leaves s_ready high. restart gives one result,
// written from the final-write state once the output register is free. a
// run step that passes the main period with a non-empty window searches the
// window for its upper median by scanning it once per candidate through a
// single memory read port: a candidate fetch, a candidate load, a scan of
// the filled entries and a rank check. then come the hand-off, the loop
// update (a median below the no-signal level ends the step with no result),
// the red/ir ratio test when due, which shares one multiplier between both
// limits, and the result writes. s_ready is high only while no item is in
// progress. a waiting result sits in the output register and words are
// still taken; a stalled receiver holds s_ready low once a further result
// is due. synchronous reset restores the register defaults, the start
// currents, zero timers and an empty window. the user is to write
// configuration only while idle; the block does not enforce it.
module led_current_agc_median_core #(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [lcam_pkg::SAMPLE_W-1:0]   s_ir_sample,
    input  logic [lcam_pkg::DC_W-1:0]       s_ir_dc,
    input  logic [lcam_pkg::DC_W-1:0]       s_red_dc,
    input  logic [lcam_pkg::TIME_W-1:0]     s_now_ms,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lcam_pkg::CODE_W-1:0]     m_ir_current,
    output logic [lcam_pkg::CODE_W-1:0]     m_red_current,
    output logic [2*lcam_pkg::CODE_W-1:0]   m_led_config,
    output logic                            m_last,

    input  logic                            cfg_wr_en,
    input  lcam_pkg::cfg_idx_t              cfg_index,
    input  logic [lcam_pkg::CFG_W-1:0]      cfg_wdata
);
    import lcam_pkg::*;

    `include "assert_macros.svh"

    logic [CFG_W-1:0]    no_signal_reg, saturation_reg, target_reg;
    logic [CFG_W-1:0]    band_below_reg, band_above_reg, coarse_reg;
    logic [RATIO_W-1:0]  ratio_floor_reg, ratio_ceil_reg;

    ctrl_state_t         state_reg, state_next;
    logic [CODE_W-1:0]   ir_code_reg, ir_code_next;
    logic [CODE_W-1:0]   red_code_reg, red_code_next;
    logic [TIME_W-1:0]   main_time_reg, main_time_next;
    logic [TIME_W-1:0]   sub_time_reg, sub_time_next;
    logic [DC_W-1:0]     ir_dc_reg, ir_dc_next;
    logic [DC_W-1:0]     red_dc_reg, red_dc_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                red_up_reg, red_up_next;

    logic                m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]   m_ir_reg, m_ir_next;
    logic [CODE_W-1:0]   m_red_reg, m_red_next;
    logic                m_last_reg, m_last_next;

    med_ctrl_t           med_ctrl;
    med_stat_t           med_stat;
    logic [SAMPLE_W-1:0] med_value;

    logic                out_free;
    logic [PROD_W-1:0]   red_scaled;
    logic [RATIO_W-1:0]  mul_coef;
    logic signed [2:0]   main_step;
    logic [CFG_W:0]      med_ext, med_plus_coarse, med_plus_below;
    logic [CFG_W:0]      tgt_ext, tgt_plus_above, tgt_plus_coarse;

    lcam_median #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (med_ctrl),
        .wr_data (s_ir_sample),
        .stat    (med_stat),
        .median  (med_value)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign red_scaled = {2'b00, red_dc_reg, 8'h00};
    assign mul_coef   = (state_reg == ST_MUL_CEIL) ? ratio_ceil_reg : ratio_floor_reg;

    assign med_ext         = {1'b0, med_value};
    assign med_plus_coarse = med_ext + {1'b0, coarse_reg};
    assign med_plus_below  = med_ext + {1'b0, band_below_reg};
    assign tgt_ext         = {1'b0, target_reg};
    assign tgt_plus_above  = tgt_ext + {1'b0, band_above_reg};
    assign tgt_plus_coarse = tgt_ext + {1'b0, coarse_reg};

    // dead-zone bands around the target
    always_comb begin
        priority if (med_plus_coarse < tgt_ext) begin
            main_step = STEP_UP2;
        end else if (med_plus_below < tgt_ext) begin
            main_step = STEP_UP1;
        end else if (med_ext <= tgt_plus_above) begin
            main_step = STEP_NONE;
        end else if (med_ext <= tgt_plus_coarse) begin
            main_step = STEP_DOWN1;
        end else begin
            main_step = STEP_DOWN2;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ir_code_next   = ir_code_reg;
        red_code_next  = red_code_reg;
        main_time_next = main_time_reg;
        sub_time_next  = sub_time_reg;
        ir_dc_next     = ir_dc_reg;
        red_dc_next    = red_dc_reg;
        now_next       = now_reg;
        prod_next      = prod_reg;
        red_up_next    = red_up_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ir_next      = m_ir_reg;
        m_red_next     = m_red_reg;
        m_last_next    = m_last_reg;
        med_ctrl       = '0;
        s_ready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_mode)
                        MODE_FEED: begin
                            med_ctrl.wr_en = 1'b1;
                        end
                        MODE_RESTART: begin
                            ir_code_next  = IR_START_CURRENT;
                            red_code_next = RED_START_CURRENT;
                            med_ctrl.clr  = 1'b1;
                            state_next    = ST_EMIT_LAST;
                        end
                        MODE_RUN: begin
                            ir_dc_next  = s_ir_dc;
                            red_dc_next = s_red_dc;
                            now_next    = s_now_ms;
                            if (!med_stat.empty
                                && ((s_now_ms - main_time_reg) >= MAIN_PERIOD_MS)) begin
                                main_time_next = s_now_ms;
                                med_ctrl.start = 1'b1;
                                state_next     = ST_MED_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MED_WAIT: begin
                if (med_stat.done) begin
                    state_next = ST_MAIN_ADJ;
                end
            end
            ST_MAIN_ADJ: begin
                if (med_value < no_signal_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    priority if (med_value >= saturation_reg) begin
                        ir_code_next = code_step(ir_code_reg, STEP_BACKOFF);
                    end else if (red_dc_reg >= {saturation_reg, 4'h0}) begin
                        red_code_next = code_step(red_code_reg, STEP_BACKOFF);
                    end else begin
                        ir_code_next = code_step(ir_code_reg, main_step);
                    end
                    if ((now_reg - sub_time_reg) < SUB_PERIOD_MS) begin
                        state_next = ST_EMIT_LAST;
                    end else begin
                        sub_time_next = now_reg;
                        state_next    = (ir_dc_reg < DC_ONE) ? ST_EMIT_LAST : ST_MUL_FLOOR;
                    end
                end
            end
            ST_MUL_FLOOR: begin
                prod_next  = mul_coef * ir_dc_reg;
                state_next = ST_CMP_FLOOR;
            end
            ST_CMP_FLOOR: begin
                if (red_scaled < prod_reg) begin
                    red_up_next = 1'b1;
                    state_next  = ST_EMIT_FIRST;
                end else begin
                    state_next = ST_MUL_CEIL;
                end
            end
            ST_MUL_CEIL: begin
                prod_next  = mul_coef * ir_dc_reg;
                state_next = ST_CMP_CEIL;
            end
            ST_CMP_CEIL: begin
                if (red_scaled > prod_reg) begin
                    red_up_next = 1'b0;
                    state_next  = ST_EMIT_FIRST;
                end else begin
                    state_next = ST_EMIT_LAST;
                end
            end
            ST_EMIT_FIRST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_ir_next     = ir_code_reg;
                    m_red_next    = red_code_reg;
                    m_last_next   = 1'b0;
                    red_code_next = code_step(red_code_reg,
                                              red_up_reg ? STEP_UP1 : STEP_DOWN1);
                    state_next    = ST_EMIT_LAST;
                end
            end
            ST_EMIT_LAST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ir_next    = ir_code_reg;
                    m_red_next   = red_code_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ir_code_reg     <= IR_START_CURRENT;
            red_code_reg    <= RED_START_CURRENT;
            main_time_reg   <= '0;
            sub_time_reg    <= '0;
            m_valid_reg     <= 1'b0;
            no_signal_reg   <= RST_NO_SIGNAL;
            saturation_reg  <= RST_SATURATION;
            target_reg      <= RST_TARGET;
            band_below_reg  <= RST_BAND_BELOW;
            band_above_reg  <= RST_BAND_ABOVE;
            coarse_reg      <= RST_COARSE;
            ratio_floor_reg <= RST_RATIO_FLOOR;
            ratio_ceil_reg  <= RST_RATIO_CEIL;
        end else begin
            state_reg     <= state_next;
            ir_code_reg   <= ir_code_next;
            red_code_reg  <= red_code_next;
            main_time_reg <= main_time_next;
            sub_time_reg  <= sub_time_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_NO_SIGNAL:   no_signal_reg   <= cfg_wdata;
                    CFG_SATURATION:  saturation_reg  <= cfg_wdata;
                    CFG_TARGET:      target_reg      <= cfg_wdata;
                    CFG_BAND_BELOW:  band_below_reg  <= cfg_wdata;
                    CFG_BAND_ABOVE:  band_above_reg  <= cfg_wdata;
                    CFG_COARSE:      coarse_reg      <= cfg_wdata;
                    CFG_RATIO_FLOOR: ratio_floor_reg <= cfg_wdata[RATIO_W-1:0];
                    CFG_RATIO_CEIL:  ratio_ceil_reg  <= cfg_wdata[RATIO_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ir_dc_reg  <= ir_dc_next;
        red_dc_reg <= red_dc_next;
        now_reg    <= now_next;
        prod_reg   <= prod_next;
        red_up_reg <= red_up_next;
        m_ir_reg   <= m_ir_next;
        m_red_reg  <= m_red_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_ir_current  = m_ir_reg;
    assign m_red_current = m_red_reg;
    assign m_led_config  = {m_ir_reg, m_red_reg};
    assign m_last        = m_last_reg;

    // a non-final word is always followed straight away by the final one
    `ASSERT_NEXT(a_pair_follows, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_last)

    // only the red current moves between the two words of a pair
    `ASSERT_NEXT(a_pair_ir_held, aclk, aresetn, m_valid && m_ready && !m_last, m_ir_current == $past(m_ir_current))

    // the median search only finishes while the sequencer waits for it
    `ASSERT_SAME(a_med_done_wait, aclk, aresetn, med_stat.done, state_reg == ST_MED_WAIT)

endmodule
